### hdl/vsu_pkg.sv
// ----------------------------------------------------------------------------
// vsu_pkg
// types, codes and constants shared by the viscous strut velocity update core
// ----------------------------------------------------------------------------
package vsu_pkg;

  localparam int unsigned MaxParticles = 16;
  localparam int unsigned IdxW         = $clog2(MaxParticles);
  localparam int unsigned CfgIdxW      = 2;

  localparam logic [31:0] StiffnessRst  = 32'd35000000;
  localparam logic [31:0] AnchorStfRst  = 32'd2450;
  localparam logic [15:0] ViscosityRst  = 16'd45875;
  localparam logic [31:0] TimeStepRst   = 32'd929645;

  typedef enum logic [1:0] {
    FUNC_WRITE  = 2'd0,
    FUNC_READ   = 2'd1,
    FUNC_PAIR   = 2'd2,
    FUNC_ANCHOR = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    STATUS_OK        = 3'd0,
    STATUS_ZERO_LEN  = 3'd1,
    STATUS_ZERO_MASS = 3'd2,
    STATUS_SAT       = 3'd4
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_STIFFNESS = 2'd0,
    CFG_ANCHOR_K  = 2'd1,
    CFG_VISCOSITY = 2'd2,
    CFG_TIME_STEP = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MDU_MUL  = 2'd0,
    MDU_DIV  = 2'd1,
    MDU_SQRT = 2'd2
  } mdu_op_e;

  typedef struct packed {
    logic [1:0]         func;
    logic [IdxW-1:0]    first_index;
    logic [IdxW-1:0]    second_index;
    logic [31:0]        rest_length;
    logic signed [47:0] pos_x;
    logic signed [47:0] pos_y;
    logic signed [47:0] pos_z;
    logic signed [47:0] vel_x;
    logic signed [47:0] vel_y;
    logic signed [47:0] vel_z;
    logic [31:0]        mass_in;
  } in_item_t;

  typedef struct packed {
    logic [IdxW-1:0]    index_out;
    logic signed [47:0] out_pos_x;
    logic signed [47:0] out_pos_y;
    logic signed [47:0] out_pos_z;
    logic signed [47:0] out_vel_x;
    logic signed [47:0] out_vel_y;
    logic signed [47:0] out_vel_z;
    logic [31:0]        out_mass;
    logic [2:0]         status;
  } out_item_t;

  // one particle entry, axis 0 is x
  typedef struct packed {
    logic [2:0][47:0] pos;
    logic [2:0][47:0] vel;
    logic [31:0]      mass;
  } particle_t;

endpackage

### hdl/vsu_store.sv
// ----------------------------------------------------------------------------
// vsu_store
// particle table, one write port and one registered read port
// ----------------------------------------------------------------------------
module vsu_store import vsu_pkg::*; (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [IdxW-1:0] waddr_i,
  input  particle_t       wdata_i,
  input  logic [IdxW-1:0] raddr_i,
  output particle_t       rdata_o
);

  particle_t mem_q [MaxParticles];
  particle_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/vsu_mdu.sv
// ----------------------------------------------------------------------------
// vsu_mdu
// shared bit-serial unit: 64x64 multiply, 128/32 divide, 64-bit square root
// ----------------------------------------------------------------------------
module vsu_mdu import vsu_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  mdu_op_e       op_i,
  input  logic [63:0]   a_i,
  input  logic [63:0]   b_i,
  input  logic [31:0]   c_i,
  output logic          done_o,
  output logic [127:0]  res_o
);

  localparam logic [6:0] MulLast  = 7'd63;
  localparam logic [6:0] DivLast  = 7'd127;
  localparam logic [6:0] SqrtLast = 7'd31;
  localparam logic [63:0] SqrtBit0 = 64'h4000_0000_0000_0000;

  logic          busy_q, done_q;
  mdu_op_e       op_q;
  logic [6:0]    cnt_q;
  logic [127:0]  acc_q;
  logic [63:0]   mc_q, mp_q;
  logic [31:0]   div_q, rem_q;
  logic [32:0]   rem_sh, rem_sub;
  logic          rem_ge;
  logic [63:0]   sq_try;
  logic          sq_ge;

  always_comb begin
    rem_sh  = {rem_q, acc_q[127]};
    rem_sub = rem_sh - {1'b0, div_q};
    rem_ge  = rem_sh >= {1'b0, div_q};
    sq_try  = mc_q + mp_q;
    sq_ge   = acc_q[63:0] >= sq_try;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= MDU_MUL;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        op_q   <= op_i;
        unique case (op_i)
          MDU_MUL:  cnt_q <= MulLast;
          MDU_DIV:  cnt_q <= DivLast;
          MDU_SQRT: cnt_q <= SqrtLast;
          default:  cnt_q <= MulLast;
        endcase
      end else if (busy_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      unique case (op_i)
        MDU_MUL: begin
          acc_q <= '0;
          mc_q  <= a_i;
          mp_q  <= b_i;
        end
        MDU_DIV: begin
          rem_q <= '0;
          div_q <= c_i;
        end
        MDU_SQRT: begin
          acc_q <= {64'd0, a_i};
          mc_q  <= '0;
          mp_q  <= SqrtBit0;
        end
        default: ;
      endcase
    end else if (busy_q) begin
      unique case (op_q)
        MDU_MUL: begin
          acc_q <= {acc_q[126:0], 1'b0} + (mp_q[63] ? {64'd0, mc_q} : 128'd0);
          mp_q  <= {mp_q[62:0], 1'b0};
        end
        MDU_DIV: begin
          acc_q <= {acc_q[126:0], rem_ge};
          rem_q <= rem_ge ? rem_sub[31:0] : rem_sh[31:0];
        end
        MDU_SQRT: begin
          if (sq_ge) begin
            acc_q[63:0] <= acc_q[63:0] - sq_try;
            mc_q        <= (mc_q >> 1) + mp_q;
          end else begin
            mc_q <= mc_q >> 1;
          end
          mp_q <= mp_q >> 2;
        end
        default: ;
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = (op_q == MDU_SQRT) ? {64'd0, mc_q} : acc_q;

endmodule

### hdl/viscous_strut_velocity_update_core.sv
// ----------------------------------------------------------------------------
// viscous_strut_velocity_update_core
// particle table with spring/damper strut velocity update on a shared unit
// ----------------------------------------------------------------------------
// pair and anchor struts run on the shared bit-serial multiply (64 steps),
//   divide (128 steps) and root (32 steps)
// one transaction at a time: in_stall_o is high from acceptance until the
//   result is loaded into the output register
// reset restores control and configuration; the particle table holds garbage
// ----------------------------------------------------------------------------
module viscous_strut_velocity_update_core import vsu_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_WR_IN  = 4'd1;
  localparam logic [3:0] S_RD_S   = 4'd2;
  localparam logic [3:0] S_RD_P   = 4'd3;
  localparam logic [3:0] S_LAT_P  = 4'd4;
  localparam logic [3:0] S_CHECK  = 4'd5;
  localparam logic [3:0] S_OP     = 4'd6;
  localparam logic [3:0] S_WAIT   = 4'd7;
  localparam logic [3:0] S_WB_P   = 4'd8;
  localparam logic [3:0] S_WB_S   = 4'd9;
  localparam logic [3:0] S_RD_OUT = 4'd10;
  localparam logic [3:0] S_OUT_LD = 4'd11;

  // steps of the strut computation on the shared unit
  localparam logic [3:0] ST_DOT   = 4'd0;
  localparam logic [3:0] ST_SQ    = 4'd1;
  localparam logic [3:0] ST_SQRT  = 4'd2;
  localparam logic [3:0] ST_TMUL  = 4'd3;
  localparam logic [3:0] ST_TDIV  = 4'd4;
  localparam logic [3:0] ST_FMUL  = 4'd5;
  localparam logic [3:0] ST_GMUL  = 4'd6;
  localparam logic [3:0] ST_IMUL  = 4'd7;
  localparam logic [3:0] ST_WSMUL = 4'd8;
  localparam logic [3:0] ST_WSDIV = 4'd9;
  localparam logic [3:0] ST_WPMUL = 4'd10;
  localparam logic [3:0] ST_WPDIV = 4'd11;
  localparam logic [3:0] ST_VSMUL = 4'd12;
  localparam logic [3:0] ST_VSDIV = 4'd13;
  localparam logic [3:0] ST_VPMUL = 4'd14;
  localparam logic [3:0] ST_VPDIV = 4'd15;

  localparam logic [1:0]  AxisLast = 2'd2;
  localparam logic [63:0] SpeedOne = 64'h0000_0000_0100_0000;  // 2^24
  localparam logic [16:0] FacOne   = 17'h1_0000;

  // clamp dv to 2^48, add or subtract, clamp to 48-bit signed; msb is sat flag
  function automatic logic [48:0] sat_add(input logic [47:0] v, input logic [63:0] dv,
                                          input logic plus);
    logic [48:0] dvc;
    logic [49:0] s;
    logic        in_rng;
    dvc = (dv > 64'h0001_0000_0000_0000) ? 49'h1_0000_0000_0000 : dv[48:0];
    s   = plus ? ({{2{v[47]}}, v} + {1'b0, dvc}) : ({{2{v[47]}}, v} - {1'b0, dvc});
    in_rng = (s[49:47] == 3'b000) || (s[49:47] == 3'b111);
    if (in_rng) begin
      sat_add = {1'b0, s[47:0]};
    end else if (s[49]) begin
      sat_add = {1'b1, 48'h8000_0000_0000};
    end else begin
      sat_add = {1'b1, 48'h7FFF_FFFF_FFFF};
    end
  endfunction

  // configuration registers, writable at any time the block is idle
  logic [31:0] stiff_q, astiff_q, dt_q;
  logic [15:0] visc_q;

  logic [3:0]  state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stiff_q  <= StiffnessRst;
      astiff_q <= AnchorStfRst;
      visc_q   <= ViscosityRst;
      dt_q     <= TimeStepRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_STIFFNESS: stiff_q  <= cfg_data_i;
        CFG_ANCHOR_K:  astiff_q <= cfg_data_i;
        CFG_VISCOSITY: visc_q   <= cfg_data_i[15:0];
        CFG_TIME_STEP: dt_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = (state_q == S_IDLE);

  // sequencer and datapath registers
  logic [3:0]  step_q, step_d;
  logic [1:0]  axis_q, axis_d;
  status_e     status_q, status_d;
  in_item_t    item_q;
  particle_t   ps_q, pp_q;
  logic signed [39:0] d_q  [3];
  logic signed [48:0] vr_q [3];
  logic [91:0] dot_q;
  logic [63:0] sum_q;
  logic [31:0] len_q;
  logic [32:0] off_q;
  logic [63:0] wv_q, ws_q, wp_q;
  logic        ovf_q, sat_q;
  logic [2:0][47:0] nvs_q, nvp_q;
  out_item_t   out_q;
  logic        out_vld_q;

  // store and shared unit ports
  logic            st_we;
  logic [IdxW-1:0] st_waddr, st_raddr;
  particle_t       st_wdata, st_rdata;
  logic            mdu_start, mdu_done;
  mdu_op_e         mdu_op;
  logic [63:0]     mdu_a, mdu_b;
  logic [31:0]     mdu_c;
  logic [127:0]    mdu_res;

  vsu_store u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  vsu_mdu u_mdu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mdu_start),
    .op_i    (mdu_op),
    .a_i     (mdu_a),
    .b_i     (mdu_b),
    .c_i     (mdu_c),
    .done_o  (mdu_done),
    .res_o   (mdu_res)
  );

  logic anch;
  assign anch = (item_q.func == FUNC_ANCHOR);

  // per-axis magnitudes of the latched difference vectors
  logic [38:0] dmag [3];
  logic [30:0] qv   [3];
  logic [48:0] vmag [3];
  logic [39:0] dneg [3];
  logic [48:0] vneg [3];
  // check stage: differences straight from the two latched ends
  logic [48:0] dc   [3];
  logic [48:0] dcn  [3];
  logic [48:0] vrc  [3];
  logic        far;

  always_comb begin
    far = 1'b0;
    for (int k = 0; k < 3; k++) begin
      dneg[k] = -d_q[k];
      dmag[k] = d_q[k][39] ? dneg[k][38:0] : d_q[k][38:0];
      qv[k]   = dmag[k][38:8];
      vneg[k] = -vr_q[k];
      vmag[k] = vr_q[k][48] ? vneg[k] : vr_q[k];
      dc[k]   = {pp_q.pos[k][47], pp_q.pos[k]} - {ps_q.pos[k][47], ps_q.pos[k]};
      dcn[k]  = -dc[k];
      vrc[k]  = {pp_q.vel[k][47], pp_q.vel[k]} - {ps_q.vel[k][47], ps_q.vel[k]};
      // far apart when |d| reaches 2^39
      if (dc[k][48] ? (dcn[k][48:39] != '0) : (dc[k][47:39] != '0)) begin
        far = 1'b1;
      end
    end
  end

  // strut terms
  logic [32:0] off_neg;
  logic [31:0] off_mag;
  logic [16:0] fac;
  logic        pos_dir, off_pos, d_pos;
  logic        ovf_new, ovf_all;
  logic [48:0] sat_res;
  logic        sat_all;

  always_comb begin
    off_neg = -off_q;
    off_mag = off_q[32] ? off_neg[31:0] : off_q[31:0];
    // damping raised when the closing speed works against the spring
    fac     = (dot_q[91] != off_q[32]) ? (FacOne + {1'b0, visc_q})
                                       : (FacOne - {1'b0, visc_q});
    off_pos = !off_q[32] && (off_q != '0);
    d_pos   = !d_q[axis_q][39] && (d_q[axis_q] != '0);
    pos_dir = (off_pos && d_pos) || (off_q[32] && d_q[axis_q][39]);

    unique case (step_q)
      ST_TDIV, ST_FMUL, ST_WSDIV, ST_WPDIV: ovf_new = |mdu_res[127:64];
      ST_GMUL: ovf_new = |mdu_res[127:80];
      ST_IMUL: ovf_new = |mdu_res[127:96];
      default: ovf_new = 1'b0;
    endcase
    ovf_all = ovf_q | ovf_new;

    // first end moves against the push direction, far end with it
    if (step_q == ST_VSDIV) begin
      sat_res = sat_add(ps_q.vel[axis_q], mdu_res[63:0], !pos_dir);
    end else begin
      sat_res = sat_add(pp_q.vel[axis_q], mdu_res[63:0], pos_dir);
    end
    sat_all = sat_q | sat_res[48];
  end

  // operand selection for the shared unit
  always_comb begin
    mdu_op = MDU_MUL;
    mdu_a  = wv_q;
    mdu_b  = SpeedOne;
    mdu_c  = len_q;
    unique case (step_q)
      ST_DOT: begin
        mdu_a = {25'd0, dmag[axis_q]};
        mdu_b = {15'd0, vmag[axis_q]};
      end
      ST_SQ: begin
        mdu_a = {33'd0, qv[axis_q]};
        mdu_b = {33'd0, qv[axis_q]};
      end
      ST_SQRT: begin
        mdu_op = MDU_SQRT;
        mdu_a  = sum_q;
      end
      ST_TMUL: begin
        mdu_a = {32'd0, off_mag};
        mdu_b = {32'd0, off_mag};
      end
      ST_TDIV: begin
        mdu_op = MDU_DIV;
        mdu_c  = item_q.rest_length;
      end
      ST_FMUL:  mdu_b = {32'd0, anch ? astiff_q : stiff_q};
      ST_GMUL:  mdu_b = {47'd0, fac};
      ST_IMUL:  mdu_b = {32'd0, dt_q};
      ST_WSMUL, ST_WPMUL: mdu_b = SpeedOne;
      ST_WSDIV: begin
        mdu_op = MDU_DIV;
        mdu_c  = ps_q.mass;
      end
      ST_WPDIV: begin
        mdu_op = MDU_DIV;
        mdu_c  = pp_q.mass;
      end
      ST_VSMUL: begin
        mdu_a = ws_q;
        mdu_b = {33'd0, qv[axis_q]};
      end
      ST_VPMUL: begin
        mdu_a = wp_q;
        mdu_b = {33'd0, qv[axis_q]};
      end
      ST_VSDIV, ST_VPDIV: begin
        mdu_op = MDU_DIV;
        mdu_c  = len_q;
      end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    axis_d    = axis_q;
    status_d  = status_q;
    st_we     = 1'b0;
    st_waddr  = item_q.first_index;
    st_wdata  = ps_q;
    st_raddr  = item_q.first_index;
    mdu_start = 1'b0;
    in_stall_o = (state_q != S_IDLE);

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          status_d = STATUS_OK;
          unique case (func_e'(in_data_i.func))
            FUNC_WRITE:  state_d = S_WR_IN;
            FUNC_READ:   state_d = S_RD_OUT;
            FUNC_PAIR,
            FUNC_ANCHOR: state_d = S_RD_S;
            default:     state_d = S_RD_OUT;
          endcase
        end
      end
      S_WR_IN: begin
        st_we    = 1'b1;
        st_wdata = '{pos:  {item_q.pos_z, item_q.pos_y, item_q.pos_x},
                     vel:  {item_q.vel_z, item_q.vel_y, item_q.vel_x},
                     mass: item_q.mass_in};
        state_d  = S_RD_OUT;
      end
      S_RD_S: state_d = S_RD_P;
      S_RD_P: begin
        st_raddr = item_q.second_index;
        state_d  = S_LAT_P;
      end
      S_LAT_P: state_d = S_CHECK;
      S_CHECK: begin
        step_d = ST_DOT;
        axis_d = '0;
        if (ps_q.mass == '0 || pp_q.mass == '0) begin
          status_d = STATUS_ZERO_MASS;
          state_d  = S_RD_OUT;
        end else if (far) begin
          status_d = STATUS_SAT;
          state_d  = S_RD_OUT;
        end else begin
          state_d = S_OP;
        end
      end
      S_OP: begin
        mdu_start = 1'b1;
        state_d   = S_WAIT;
      end
      S_WAIT: begin
        if (mdu_done) begin
          state_d = S_OP;
          unique case (step_q)
            ST_DOT: step_d = ST_SQ;
            ST_SQ: begin
              if (axis_q == AxisLast) begin
                step_d = ST_SQRT;
                axis_d = '0;
              end else begin
                step_d = ST_DOT;
                axis_d = axis_q + 2'd1;
              end
            end
            ST_SQRT: begin
              if (mdu_res[31:0] == '0 || item_q.rest_length == '0) begin
                status_d = STATUS_ZERO_LEN;
                state_d  = S_RD_OUT;
              end else begin
                step_d = ST_TMUL;
              end
            end
            ST_TMUL:  step_d = ST_TDIV;
            ST_TDIV:  step_d = ST_FMUL;
            ST_FMUL:  step_d = ST_GMUL;
            ST_GMUL:  step_d = ST_IMUL;
            ST_IMUL:  step_d = ST_WSMUL;
            ST_WSMUL: step_d = ST_WSDIV;
            ST_WSDIV, ST_WPDIV: begin
              if (!anch && step_q == ST_WSDIV) begin
                step_d = ST_WPMUL;
              end else if (ovf_all) begin
                status_d = STATUS_SAT;
                state_d  = S_RD_OUT;
              end else begin
                step_d = ST_VSMUL;
                axis_d = '0;
              end
            end
            ST_WPMUL: step_d = ST_WPDIV;
            ST_VSMUL: step_d = ST_VSDIV;
            ST_VPMUL: step_d = ST_VPDIV;
            ST_VSDIV, ST_VPDIV: begin
              if (!anch && step_q == ST_VSDIV) begin
                step_d = ST_VPMUL;
              end else if (axis_q == AxisLast) begin
                status_d = sat_all ? STATUS_SAT : STATUS_OK;
                state_d  = anch ? S_WB_S : S_WB_P;
              end else begin
                step_d = ST_VSMUL;
                axis_d = axis_q + 2'd1;
              end
            end
            default: step_d = ST_DOT;
          endcase
        end
      end
      S_WB_P: begin
        st_we    = 1'b1;
        st_waddr = item_q.second_index;
        st_wdata = '{pos: pp_q.pos, vel: nvp_q, mass: pp_q.mass};
        state_d  = S_WB_S;
      end
      S_WB_S: begin
        st_we    = 1'b1;
        st_wdata = '{pos: ps_q.pos, vel: nvs_q, mass: ps_q.mass};
        state_d  = S_RD_OUT;
      end
      S_RD_OUT: state_d = S_OUT_LD;
      S_OUT_LD: begin
        // hold until the output register is free
        if (!out_vld_q || !out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      step_q    <= ST_DOT;
      axis_q    <= '0;
      status_q  <= STATUS_OK;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      axis_q   <= axis_d;
      status_q <= status_d;
      if (state_q == S_OUT_LD && (!out_vld_q || !out_stall_i)) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // datapath captures
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      item_q <= in_data_i;
    end
    if (state_q == S_RD_P) begin
      ps_q <= st_rdata;
    end
    if (state_q == S_LAT_P) begin
      if (anch) begin
        // anchor end: fixed point, no velocity, unit mass
        pp_q <= '{pos:  {item_q.pos_z, item_q.pos_y, item_q.pos_x},
                  vel:  '0,
                  mass: 32'd1};
      end else begin
        pp_q <= st_rdata;
      end
    end
    if (state_q == S_CHECK) begin
      for (int k = 0; k < 3; k++) begin
        d_q[k]  <= dc[k][39:0];
        vr_q[k] <= vrc[k];
      end
      dot_q <= '0;
      sum_q <= '0;
      ovf_q <= 1'b0;
      sat_q <= 1'b0;
    end
    if (state_q == S_WAIT && mdu_done) begin
      ovf_q <= ovf_all;
      case (step_q)
        ST_DOT: begin
          if (d_q[axis_q][39] ^ vr_q[axis_q][48]) begin
            dot_q <= dot_q - mdu_res[91:0];
          end else begin
            dot_q <= dot_q + mdu_res[91:0];
          end
        end
        ST_SQ: sum_q <= sum_q + mdu_res[63:0];
        ST_SQRT: begin
          len_q <= mdu_res[31:0];
          off_q <= {1'b0, item_q.rest_length} - {1'b0, mdu_res[31:0]};
        end
        ST_TDIV, ST_FMUL: wv_q <= mdu_res[63:0];
        ST_GMUL:  wv_q <= mdu_res[79:16];
        ST_IMUL:  wv_q <= mdu_res[95:32];
        ST_WSDIV: ws_q <= mdu_res[63:0];
        ST_WPDIV: wp_q <= mdu_res[63:0];
        ST_VSDIV: begin
          nvs_q[axis_q] <= sat_res[47:0];
          sat_q         <= sat_all;
        end
        ST_VPDIV: begin
          nvp_q[axis_q] <= sat_res[47:0];
          sat_q         <= sat_all;
        end
        default: ;
      endcase
    end
    if (state_q == S_OUT_LD && (!out_vld_q || !out_stall_i)) begin
      out_q.index_out <= item_q.first_index;
      out_q.out_pos_x <= st_rdata.pos[0];
      out_q.out_pos_y <= st_rdata.pos[1];
      out_q.out_pos_z <= st_rdata.pos[2];
      out_q.out_vel_x <= st_rdata.vel[0];
      out_q.out_vel_y <= st_rdata.vel[1];
      out_q.out_vel_z <= st_rdata.vel[2];
      out_q.out_mass  <= st_rdata.mass;
      out_q.status    <= status_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

### hdl/vsu_checker.sv
// ----------------------------------------------------------------------------
// vsu_port_checker
// port-level assertions for the viscous strut velocity update core
// ----------------------------------------------------------------------------
module vsu_port_checker import vsu_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input in_item_t           in_data_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input out_item_t          out_data_o,
  input logic               cfg_valid_i,
  input logic               cfg_ready_o,
  input logic [CfgIdxW-1:0] cfg_index_i,
  input logic [31:0]        cfg_data_i
);

  // a pending result is not dropped
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // one transaction at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while busy");

  // a result never appears right after a transaction is taken
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !$rose(out_valid_o))
    else $error("result too early");

  // only defined status codes leave the block
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status == STATUS_OK) ||
                    (out_data_o.status == STATUS_ZERO_LEN) ||
                    (out_data_o.status == STATUS_ZERO_MASS) ||
                    (out_data_o.status == STATUS_SAT))
    else $error("undefined status code");

endmodule

bind viscous_strut_velocity_update_core vsu_port_checker u_vsu_checker (.*);

### dv/vsu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsu_checker
// watches the item, result and register channels of the strut core, keeps
// its own copy of the particle table and registers, predicts every result
// and compares it field by field in order of arrival
// ----------------------------------------------------------------------------
module vsu_checker import vsu_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  in_item_t           in_data_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  out_item_t          out_data_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  particle_t   table_q [MaxParticles];
  logic [31:0] pair_k, anchor_k, time_step;
  logic [15:0] viscosity;
  out_item_t   expected_results [$];

  function automatic logic [63:0] magnitude(logic signed [63:0] x);
    return x < 0 ? 64'(-x) : 64'(x);
  endfunction

  // returns {overflow, floor(a*b/c)}
  function automatic logic [64:0] mul_div(logic [63:0] a, logic [63:0] b, logic [63:0] c);
    logic [127:0] p, qq;
    if (c == 0) return {1'b1, 64'd0};
    p  = a * b;
    qq = p / c;
    return {|qq[127:64], qq[63:0]};
  endfunction

  // returns {overflow, floor(a*b / 2^sh)}
  function automatic logic [64:0] mul_shift(logic [63:0] a, logic [63:0] b, int sh);
    logic [127:0] p;
    p = a * b;
    p = p >> sh;
    return {|p[127:64], p[63:0]};
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] res, b;
    res = 0;
    b   = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x   = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // returns {saturated, new velocity}
  function automatic logic [48:0] add_clamped(logic [47:0] stored, logic [63:0] dv, bit plus);
    logic signed [63:0] v, d;
    logic sat;
    sat = 1'b0;
    v   = $signed(stored);
    if (dv > (64'd1 << 48)) dv = 64'd1 << 48;
    d = $signed(dv);
    v = plus ? v + d : v - d;
    if (v > 64'sh7FFF_FFFF_FFFF) begin
      v   = 64'sh7FFF_FFFF_FFFF;
      sat = 1'b1;
    end
    if (v < -64'sh8000_0000_0000) begin
      v   = -64'sh8000_0000_0000;
      sat = 1'b1;
    end
    return {sat, v[47:0]};
  endfunction

  function automatic logic [2:0] apply_strut(int s, int p, bit anch, in_item_t it);
    logic [63:0]        ms, mp, sum, len, a, t, f, g, imp, ws, wp, fac;
    logic [63:0]        q [3];
    logic signed [63:0] d [3];
    logic signed [63:0] ps, pe, vr, off;
    logic signed [127:0] dot, w1, w2;
    logic signed [47:0] anc [3];
    logic [47:0]        nvs [3], nvp [3];
    logic [64:0]        r;
    logic [48:0]        sv;
    bit                 ovf, sat, offneg, dotneg, pdir;
    ovf = 0;
    sat = 0;
    sum = 0;
    dot = 0;
    anc[0] = it.pos_x;
    anc[1] = it.pos_y;
    anc[2] = it.pos_z;
    ms = 64'(table_q[s].mass);
    mp = anch ? 64'd1 : 64'(table_q[p].mass);
    if (ms == 0 || mp == 0) return STATUS_ZERO_MASS;
    for (int k = 0; k < 3; k++) begin
      ps = $signed(table_q[s].pos[k]);
      pe = anch ? 64'(anc[k]) : 64'($signed(table_q[p].pos[k]));
      if (anch) vr = -64'($signed(table_q[s].vel[k]));
      else vr = 64'($signed(table_q[p].vel[k])) - 64'($signed(table_q[s].vel[k]));
      d[k] = pe - ps;
      if (magnitude(d[k]) >= (64'd1 << 39)) return STATUS_SAT;
      q[k] = magnitude(d[k]) >> 8;
      sum  = sum + q[k] * q[k];
      w1   = d[k];
      w2   = vr;
      dot  = dot + w1 * w2;
    end
    len = int_sqrt(sum);
    if (len == 0 || it.rest_length == 0) return STATUS_ZERO_LEN;

    off    = $signed({32'd0, it.rest_length}) - $signed(len);
    offneg = off < 0;
    dotneg = dot < 0;
    a      = magnitude(off);
    r = mul_div(a, a, 64'(it.rest_length));           ovf |= r[64]; t = r[63:0];
    r = mul_shift(t, anch ? 64'(anchor_k) : 64'(pair_k), 0); ovf |= r[64]; f = r[63:0];
    fac = (dotneg != offneg) ? 64'd65536 + viscosity : 64'd65536 - viscosity;
    r = mul_shift(f, fac, 16);                        ovf |= r[64]; g = r[63:0];
    r = mul_shift(g, 64'(time_step), 32);             ovf |= r[64]; imp = r[63:0];
    r = mul_div(imp, 64'd1 << 24, ms);                ovf |= r[64]; ws = r[63:0];
    wp = 0;
    if (!anch) begin
      r = mul_div(imp, 64'd1 << 24, mp); ovf |= r[64]; wp = r[63:0];
    end
    if (ovf) return STATUS_SAT;

    for (int k = 0; k < 3; k++) begin
      pdir = (off > 0 && d[k] > 0) || (off < 0 && d[k] < 0);
      r  = mul_div(ws, q[k], len);
      sv = add_clamped(table_q[s].vel[k], r[63:0], !pdir);
      sat |= sv[48];
      nvs[k] = sv[47:0];
      if (!anch) begin
        r  = mul_div(wp, q[k], len);
        sv = add_clamped(table_q[p].vel[k], r[63:0], pdir);
        sat |= sv[48];
        nvp[k] = sv[47:0];
      end
    end
    for (int k = 0; k < 3; k++) begin
      if (!anch) table_q[p].vel[k] = nvp[k];
      table_q[s].vel[k] = nvs[k];
    end
    return sat ? STATUS_SAT : STATUS_OK;
  endfunction

  function automatic out_item_t predict_particle(in_item_t it);
    out_item_t  o;
    logic [2:0] st;
    int         i;
    i  = it.first_index;
    st = STATUS_OK;
    case (func_e'(it.func))
      FUNC_WRITE: begin
        table_q[i].pos  = {it.pos_z, it.pos_y, it.pos_x};
        table_q[i].vel  = {it.vel_z, it.vel_y, it.vel_x};
        table_q[i].mass = it.mass_in;
      end
      FUNC_PAIR:   st = apply_strut(i, it.second_index, 1'b0, it);
      FUNC_ANCHOR: st = apply_strut(i, 0, 1'b1, it);
      default: ;
    endcase
    o.index_out = it.first_index;
    o.out_pos_x = table_q[i].pos[0];
    o.out_pos_y = table_q[i].pos[1];
    o.out_pos_z = table_q[i].pos[2];
    o.out_vel_x = table_q[i].vel[0];
    o.out_vel_y = table_q[i].vel[1];
    o.out_vel_z = table_q[i].vel[2];
    o.out_mass  = table_q[i].mass;
    o.status    = st;
    return o;
  endfunction

  task automatic check_field(string nm, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, nm, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    for (int i = 0; i < MaxParticles; i++) table_q[i] = '0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t e;
    if (!rst_ni) begin
      pair_k    <= StiffnessRst;
      anchor_k  <= AnchorStfRst;
      viscosity <= ViscosityRst;
      time_step <= TimeStepRst;
      expected_results.delete();
    end else begin
      // results first: a result at this edge never belongs to an item taken now
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, got %h", $time, out_data_i);
          fail_count_o++;
        end else begin
          e = expected_results.pop_front();
          check_field("index_out", 64'(e.index_out), 64'(out_data_i.index_out));
          check_field("out_pos_x", 64'(e.out_pos_x), 64'(out_data_i.out_pos_x));
          check_field("out_pos_y", 64'(e.out_pos_y), 64'(out_data_i.out_pos_y));
          check_field("out_pos_z", 64'(e.out_pos_z), 64'(out_data_i.out_pos_z));
          check_field("out_vel_x", 64'(e.out_vel_x), 64'(out_data_i.out_vel_x));
          check_field("out_vel_y", 64'(e.out_vel_y), 64'(out_data_i.out_vel_y));
          check_field("out_vel_z", 64'(e.out_vel_z), 64'(out_data_i.out_vel_z));
          check_field("out_mass", 64'(e.out_mass), 64'(out_data_i.out_mass));
          check_field("status", 64'(e.status), 64'(out_data_i.status));
        end
      end
      if (in_valid_i && !in_stall_i) expected_results.push_back(predict_particle(in_data_i));
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_STIFFNESS: pair_k    <= cfg_data_i;
          CFG_ANCHOR_K:  anchor_k  <= cfg_data_i;
          CFG_VISCOSITY: viscosity <= cfg_data_i[15:0];
          CFG_TIME_STEP: time_step <= cfg_data_i;
          default: ;
        endcase
      end
    end
    pending_o = expected_results.size();
  end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives particle writes, reads and struts into the strut core across several
// register settings, with bursty input and a stalling receiver; the checker
// beside the core predicts and compares every result
// ----------------------------------------------------------------------------
module testbench import vsu_pkg::*; ();

  localparam int WatchdogLimit = 60000;  // far above the slowest strut plus hold-off
  localparam int HoldOffCycles = 4000;
  localparam int PhaseItems    = 95;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  in_item_t           in_data_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  out_item_t          out_data_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = CFG_STIFFNESS;
  logic [31:0]        cfg_data_i = '0;
  int                 fail_count, pending_results;
  int                 idle_cycles = 0;
  int                 burst_left = 0;
  bit                 hold_off_req = 1'b0;

  // clock, 10 ns period
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  viscous_strut_velocity_update_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  vsu_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_i   (out_data_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending_results)
  );

  // watchdog: cycles with no transaction on any channel
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: stall pattern that changes mode now and then, plus a long
  // hold-off on request so that the core backs up onto its input
  initial begin
    int mode, left, hold;
    mode = 0;
    left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        out_stall_i = 1'b1;
        for (hold = 0; hold < HoldOffCycles; hold++) @(negedge clk_i);
        hold_off_req = 1'b0;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 400);
      end
      left--;
      case (mode)
        0:       out_stall_i = 1'b0;                       // no stalls
        1:       out_stall_i = ($urandom_range(0, 3) == 0);
        2:       out_stall_i = ($urandom_range(0, 1) == 0);
        default: out_stall_i = ($urandom_range(0, 9) != 0); // mostly stalled
      endcase
    end
  end

  // one item, holding valid across back-to-back items within a burst
  task automatic send_item(in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        @(negedge clk_i);
        in_valid_i = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i = 1'b1;
    in_data_i  = it;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic write_register(cfg_reg_e idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // every result in, then a margin covering the write/read latency
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    burst_left = 0;
    while (pending_results != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // small signed value, |v| at most 2^(b-1)
  function automatic logic [47:0] near48(int b);
    logic signed [47:0] v;
    v = 48'({$urandom(), $urandom()});
    return v >>> (48 - b);
  endfunction

  function automatic in_item_t fill_item(func_e fn, int i, int j);
    in_item_t it;
    it.func         = fn;
    it.first_index  = IdxW'(i);
    it.second_index = IdxW'(j);
    it.rest_length  = $urandom_range(1, 40 << 16);
    it.pos_x        = near48(30);
    it.pos_y        = near48(30);
    it.pos_z        = near48(30);
    it.vel_x        = near48(28);
    it.vel_y        = near48(28);
    it.vel_z        = near48(28);
    it.mass_in      = ($urandom_range(0, 15) == 0) ? 32'd0 : $urandom_range(1 << 10, 1 << 22);
    return it;
  endfunction

  function automatic in_item_t random_item();
    in_item_t     it;
    int           pick;
    logic [383:0] raw;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      // noise: every field at full range; writes leave far-flung particles
      raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
             $urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
      it  = raw[$bits(in_item_t)-1:0];
      if (func_e'(it.func) != FUNC_WRITE && $urandom_range(0, 1) == 0) it.func = FUNC_READ;
    end else if (pick < 28) begin
      it = fill_item(FUNC_WRITE, $urandom_range(0, 15), 0);
    end else if (pick < 40) begin
      it = fill_item(FUNC_READ, $urandom_range(0, 15), $urandom_range(0, 15));
    end else if (pick < 72) begin
      it = fill_item(FUNC_PAIR, $urandom_range(0, 15), $urandom_range(0, 15));
    end else begin
      it = fill_item(FUNC_ANCHOR, $urandom_range(0, 15), 0);
    end
    return it;
  endfunction

  initial begin
    in_item_t it;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: defined table first, then the corner cases
    for (int i = 0; i < MaxParticles; i++) begin
      it = fill_item(FUNC_WRITE, i, 0);
      it.mass_in = 32'h0001_0000;
      if (i == 12) it.mass_in = '1;                   // largest mass
      if (i == 13) it.mass_in = '0;                   // massless particle
      if (i == 14) begin                              // extreme positive fields
        it.pos_x = 48'h7FFF_FFFF_FFFF;
        it.vel_y = 48'h7FFF_FFFF_FFFF;
      end
      if (i == 15) begin                              // extreme negative fields
        it.pos_x = 48'h8000_0000_0000;
        it.vel_z = 48'h8000_0000_0000;
      end
      send_item(it);
    end
    it = fill_item(FUNC_READ, 15, 15);
    it.rest_length = '1;
    send_item(it);
    send_item(fill_item(FUNC_PAIR, 3, 3));            // strut to itself, zero length
    send_item(fill_item(FUNC_PAIR, 13, 2));           // massless end
    send_item(fill_item(FUNC_PAIR, 14, 15));          // ends too far apart
    it = fill_item(FUNC_ANCHOR, 4, 0);
    it.rest_length = '0;                              // zero rest length
    send_item(it);
    send_item(fill_item(FUNC_PAIR, 1, 2));
    send_item(fill_item(FUNC_ANCHOR, 5, 0));
    wait_drained();

    // register phases: default values, zeros, all ones, random, back to default
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_register(CFG_STIFFNESS, StiffnessRst);
          write_register(CFG_ANCHOR_K, AnchorStfRst);
          write_register(CFG_VISCOSITY, 32'(ViscosityRst));
          write_register(CFG_TIME_STEP, TimeStepRst);
        end
        1: begin
          write_register(CFG_STIFFNESS, '0);
          write_register(CFG_ANCHOR_K, '0);
          write_register(CFG_VISCOSITY, '0);
          write_register(CFG_TIME_STEP, '0);
        end
        2: begin
          write_register(CFG_STIFFNESS, '1);
          write_register(CFG_ANCHOR_K, '1);
          write_register(CFG_VISCOSITY, 32'hFFFF);
          write_register(CFG_TIME_STEP, '1);
        end
        3: begin
          write_register(CFG_STIFFNESS, $urandom_range(1, 1 << 28));
          write_register(CFG_ANCHOR_K, $urandom_range(1, 1 << 20));
          write_register(CFG_VISCOSITY, $urandom_range(0, 65535));
          write_register(CFG_TIME_STEP, $urandom());
        end
        default: begin
          write_register(CFG_STIFFNESS, StiffnessRst);
          write_register(CFG_ANCHOR_K, AnchorStfRst);
          write_register(CFG_VISCOSITY, 32'(ViscosityRst));
          write_register(CFG_TIME_STEP, TimeStepRst);
        end
      endcase
      for (int n = 0; n < PhaseItems; n++) begin
        // long receiver hold-off while items keep coming
        if (ph == 0 && n == 10) hold_off_req = 1'b1;
        send_item(random_item());
      end
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/vsu_pkg.sv
hdl/vsu_store.sv
hdl/vsu_mdu.sv
hdl/viscous_strut_velocity_update_core.sv
hdl/vsu_checker.sv
dv/vsu_checker.sv
dv/testbench.sv
